[rtl/core/cmaf_pkg.sv]
// shared types and constants of the centered moving average filter core
package cmaf_pkg;

  // default build sizes
  localparam int MAX_WINDOW_DEF  = 31;
  localparam int SAMPLE_BITS_DEF = 16;

  // width of the window size register
  localparam int WIN_W = 5;

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = WIN_W;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PASS_MODE   = 1'd1;
  localparam logic [WIN_W-1:0]      WINDOW_SIZE_RST = 5'd3;

  // read position operations
  typedef enum logic [2:0] {
    POS_HOLD,
    POS_H,
    POS_ZERO,
    POS_INC,
    POS_DEC,
    POS_M1
  } pos_op_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_CTR,
    S_CTR_LAT,
    S_SUM0,
    S_SUM,
    S_SUM_END,
    S_DIV_LD,
    S_DIV,
    S_EMIT,
    S_FL_RD,
    S_FL_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    pos_op_t pos_op;
    logic    sample_ld;
    logic    acc_clr;
    logic    acc_add;
    logic    div_init;
    logic    div_step;
    logic    emit_main;
    logic    emit_flush;
  } cmaf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic emit;
    logic interior;
    logic odd;
    logic last;
    logic m_zero;
    logic pos_at_end;
    logic pos_zero;
    logic div_done;
    logic out_free;
  } cmaf_sts_t;

endpackage

[rtl/core/cmaf_ctrl.sv]
// controller state machine of the centered moving average filter
module cmaf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  cmaf_pkg::cmaf_sts_t sts,
  output cmaf_pkg::cmaf_cmd_t cmd
);
  import cmaf_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.pos_op = POS_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (sts.emit) begin
          cmd.pos_op = POS_H;
          state_nxt  = S_CTR;
        end else if (sts.last && !sts.m_zero) begin
          cmd.pos_op = POS_M1;
          state_nxt  = S_FL_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CTR: begin
        state_nxt = S_CTR_LAT;
      end
      S_CTR_LAT: begin
        cmd.sample_ld = 1'b1;
        if (sts.interior && sts.odd) begin
          cmd.pos_op  = POS_ZERO;
          cmd.acc_clr = 1'b1;
          state_nxt   = S_SUM0;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_SUM0: begin
        if (sts.pos_at_end) begin
          state_nxt = S_SUM_END;
        end else begin
          cmd.pos_op = POS_INC;
          state_nxt  = S_SUM;
        end
      end
      S_SUM: begin
        cmd.acc_add = 1'b1;
        if (sts.pos_at_end) begin
          state_nxt = S_SUM_END;
        end else begin
          cmd.pos_op = POS_INC;
        end
      end
      S_SUM_END: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_DIV_LD;
      end
      S_DIV_LD: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_main = 1'b1;
          if (sts.last && !sts.m_zero) begin
            cmd.pos_op = POS_M1;
            state_nxt  = S_FL_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FL_RD: begin
        state_nxt = S_FL_EMIT;
      end
      S_FL_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_flush = 1'b1;
          if (sts.pos_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.pos_op = POS_DEC;
            state_nxt  = S_FL_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/cmaf_dp.sv]
// datapath: sample history memory, window sum, serial divider and output register
module cmaf_dp #(
  parameter int MAX_WINDOW  = cmaf_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = cmaf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [cmaf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cmaf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // accepted input word
  input  logic [SAMPLE_BITS-1:0]          in_sample,
  input  logic                            in_last,
  // result register
  input  logic                            out_tready,
  output logic                            out_valid,
  output logic [SAMPLE_BITS:0]            out_value,
  output logic                            out_final,
  // control
  input  cmaf_pkg::cmaf_cmd_t             cmd,
  output cmaf_pkg::cmaf_sts_t             sts
);
  import cmaf_pkg::*;

  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int PW    = (AW > WIN_W) ? AW : WIN_W;
  localparam int CW    = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int OW    = SAMPLE_BITS + 1;
  localparam int DC_W  = $clog2(SUM_W + 1);

  // configuration registers
  logic [WIN_W-1:0] win_cfg_r;
  logic             pass_r;

  // stream control state
  logic [CNT_W-1:0] rc_r;
  logic [AW-1:0]    newest_r;
  logic             last_r;
  logic             emit_r;
  logic             interior_r;
  logic [PW-1:0]    m_r;
  logic [PW-1:0]    pos_r;

  // payload
  logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rdata_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SUM_W-1:0]       acc_r;
  logic [SUM_W-1:0]       quo_r;
  logic [WIN_W-1:0]       rem_r;
  logic                   neg_r;
  logic [DC_W-1:0]        dcnt_r;
  logic                   out_valid_r;
  logic [OW-1:0]          out_value_r;
  logic                   out_final_r;

  // effective window and half window
  logic [CW-1:0]    win_ext;
  logic [WIN_W-1:0] win_e;
  logic [CW-1:0]    h_c;
  logic [CNT_W-1:0] rc_new;
  logic [CW-1:0]    rc_ext;
  logic             emit_c;
  logic             interior_c;
  logic [CW-1:0]    m_c;
  logic [PW-1:0]    last_pos;

  always_comb begin
    win_ext    = {{(CW-WIN_W){1'b0}}, win_cfg_r};
    if (win_ext > CW'(MAX_WINDOW)) begin
      win_ext = CW'(MAX_WINDOW);
    end
    win_e      = win_ext[WIN_W-1:0];
    h_c        = {{(CW-WIN_W+1){1'b0}}, win_e[WIN_W-1:1]};
    rc_new     = (rc_r == CNT_W'(MAX_WINDOW)) ? rc_r : rc_r + 1'b1;
    rc_ext     = {{(CW-CNT_W){1'b0}}, rc_new};
    emit_c     = (rc_ext >= h_c + 1'b1);
    interior_c = (rc_ext >= (h_c << 1) + 1'b1);
    m_c        = emit_c ? h_c : rc_ext;
    last_pos   = PW'(win_e) - 1'b1;
  end

  // circular history: position 0 is the newest sample
  logic [AW-1:0] wr_idx;
  logic [PW:0]   nw_ext;
  logic [PW:0]   pos_ext;
  logic [PW:0]   raw_addr;
  logic [AW-1:0] rd_addr;

  always_comb begin
    wr_idx   = (newest_r == AW'(MAX_WINDOW - 1)) ? '0 : newest_r + 1'b1;
    nw_ext   = {{(PW+1-AW){1'b0}}, newest_r};
    pos_ext  = {1'b0, pos_r};
    raw_addr = (pos_ext > nw_ext) ? nw_ext + (PW+1)'(MAX_WINDOW) - pos_ext
                                  : nw_ext - pos_ext;
    rd_addr  = raw_addr[AW-1:0];
  end

  // history memory
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[wr_idx] <= in_sample;
    end
    rdata_r <= mem[rd_addr];
  end

  // divider step
  logic [WIN_W:0] rem_sh;
  logic [WIN_W:0] rem_diff;
  logic           q_bit;

  always_comb begin
    rem_sh   = {rem_r, quo_r[SUM_W-1]};
    rem_diff = rem_sh - {1'b0, win_e};
    q_bit    = (rem_sh >= {1'b0, win_e});
  end

  // result value
  logic [OW-1:0] s_ext;
  logic [OW-1:0] q_low;
  logic [OW-1:0] lp_div;
  logic [OW-1:0] lp_main;
  logic [OW-1:0] val_main;
  logic [OW-1:0] val_flush;
  logic          out_free;

  always_comb begin
    s_ext     = {sample_r[SAMPLE_BITS-1], sample_r};
    q_low     = quo_r[OW-1:0];
    lp_div    = neg_r ? -q_low : q_low;
    lp_main   = interior_r ? (win_e[0] ? lp_div : s_ext) : '0;
    val_main  = pass_r ? s_ext - lp_main : lp_main;
    val_flush = pass_r ? {rdata_r[SAMPLE_BITS-1], rdata_r} : '0;
    out_free  = !out_valid_r || out_tready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r   <= WINDOW_SIZE_RST;
      pass_r      <= 1'b0;
      rc_r        <= '0;
      newest_r    <= '0;
      last_r      <= 1'b0;
      emit_r      <= 1'b0;
      interior_r  <= 1'b0;
      m_r         <= '0;
      pos_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_WINDOW_SIZE: win_cfg_r <= cfg_wdata;
          REG_PASS_MODE:   pass_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
      // accept a sample
      if (cmd.load) begin
        newest_r   <= wr_idx;
        rc_r       <= in_last ? '0 : rc_new;
        last_r     <= in_last;
        emit_r     <= emit_c;
        interior_r <= interior_c;
        m_r        <= m_c[PW-1:0];
      end
      // read position
      case (cmd.pos_op)
        POS_H:    pos_r <= h_c[PW-1:0];
        POS_ZERO: pos_r <= '0;
        POS_INC:  pos_r <= pos_r + 1'b1;
        POS_DEC:  pos_r <= pos_r - 1'b1;
        POS_M1:   pos_r <= m_r - 1'b1;
        default:  pos_r <= pos_r;
      endcase
      // divider bit count
      if (cmd.div_init) begin
        dcnt_r <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + 1'b1;
      end
      // result register handshake
      if (cmd.emit_main || cmd.emit_flush) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.sample_ld) begin
      sample_r <= rdata_r;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + {{CNT_W{rdata_r[SAMPLE_BITS-1]}}, rdata_r};
    end
    // magnitude division, one quotient bit a cycle
    if (cmd.div_init) begin
      neg_r <= acc_r[SUM_W-1];
      quo_r <= acc_r[SUM_W-1] ? -acc_r : acc_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_diff[WIN_W-1:0] : rem_sh[WIN_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], q_bit};
    end
    if (cmd.emit_main) begin
      out_value_r <= val_main;
      out_final_r <= last_r && (m_r == '0);
    end else if (cmd.emit_flush) begin
      out_value_r <= val_flush;
      out_final_r <= (pos_r == '0);
    end
  end

  // status
  always_comb begin
    sts.emit       = emit_r;
    sts.interior   = interior_r;
    sts.odd        = win_e[0];
    sts.last       = last_r;
    sts.m_zero     = (m_r == '0);
    sts.pos_at_end = (pos_r == last_pos);
    sts.pos_zero   = (pos_r == '0);
    sts.div_done   = (dcnt_r == DC_W'(SUM_W));
    sts.out_free   = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_final = out_final_r;

endmodule

[rtl/core/centered_moving_average_filter_core.sv]
// top level of the centered moving average filter core
//
//  channel   direction  handshake             payload
//  in_*      slave      tvalid/tready         tdata = sample, tlast = last
//  out_*     master     tvalid/tready         tdata = value, tlast = final_res
//  cfg_*     slave      write enable only     cfg_addr = register, cfg_wdata = data
//
// one word is worked on at a time: the next word is accepted only once the results of the
// last one are in the result register. The time an item takes is set by the single memory
// read port and the one-bit-a-cycle divider; an odd interior window is summed and divided,
// and each flushed edge result is read from the history and emitted in turn.
// reset clears control state only; history entries are never read before written.
// a stalled result register holds the next result back, and input waits meanwhile.
module centered_moving_average_filter_core #(
  parameter int MAX_WINDOW  = cmaf_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = cmaf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   in_tdata,  // sample
  input  logic                               in_tlast,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((SAMPLE_BITS+8)/8)*8-1:0]   out_tdata, // value, zero pad
  output logic                               out_tlast,
  // configuration
  input  logic                               cfg_we,
  input  logic [cmaf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [cmaf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import cmaf_pkg::*;

  localparam int OUT_W = ((SAMPLE_BITS + 8) / 8) * 8;

  cmaf_cmd_t cmd;
  cmaf_sts_t sts;
  logic [SAMPLE_BITS:0] out_value;

  // sequencer
  cmaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  cmaf_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (in_tdata[SAMPLE_BITS-1:0]),
    .in_last    (in_tlast),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_value  (out_value),
    .out_final  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  // pack the result word
  assign out_tdata = {{(OUT_W-SAMPLE_BITS-1){1'b0}}, out_value};

endmodule

[tb/centered_moving_average_filter_core_tb.sv]
// testbench of the centered moving average filter core with a built-in filter predictor
`timescale 1ns / 100ps

module centered_moving_average_filter_core_tb;
  import cmaf_pkg::*;

  localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
  localparam int MAX_WIN      = MAX_WINDOW_DEF;
  localparam int IN_W         = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W        = ((SAMPLE_BITS + 8) / 8) * 8;
  localparam int ITEMS_TARGET = 230;
  localparam int QUIET_CYCLES = 64;

  // one filtered word as the block should deliver it
  typedef struct packed {
    logic signed [SAMPLE_BITS:0] value;
    logic                        final_res;
  } avg_word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata = '0;   // sample
  logic                   in_tlast = 1'b0; // last
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_W-1:0]       out_tdata;       // value, zero pad
  logic                   out_tlast;       // final_res
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // filter state as predicted
  logic [WIN_W-1:0]              win_reg = WINDOW_SIZE_RST;
  logic                          hp_mode = 1'b0;
  logic signed [SAMPLE_BITS-1:0] hist [MAX_WIN];
  int                            hist_cnt = 0;
  avg_word_t                     avg_q [$];

  int  mismatches = 0;
  int  items_sent = 0;
  bit  in_gaps_on = 1'b1;
  bit  out_stalls_on = 1'b1;

  centered_moving_average_filter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // value of the output whose sample sits at history position pos
  function automatic logic signed [SAMPLE_BITS:0] filtered(int pos, bit interior, int win,
                                                           int h);
    int s;
    int lp;
    int acc;
    s = hist[pos];
    lp = 0;
    acc = 0;
    if (interior) begin
      // odd windows average, even ones (zero included) pass the centered sample
      if (win % 2 == 1) begin
        for (int i = 0; i <= 2 * h && i < MAX_WIN; i++) acc += hist[i];
        lp = acc / win;
      end else begin
        lp = s;
      end
    end
    return hp_mode ? s - lp : lp;
  endfunction

  // shift in one accepted sample and queue the words it owes
  function automatic void predict_sample(logic signed [SAMPLE_BITS-1:0] smp, logic lst);
    int win;
    int h;
    int m;
    int n;
    avg_word_t w;
    win = (win_reg > MAX_WIN) ? MAX_WIN : win_reg;
    h = win / 2;
    n = 0;
    for (int i = MAX_WIN - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = smp;
    if (hist_cnt < MAX_WIN) hist_cnt++;
    // centered output once h samples of lookahead exist
    if (hist_cnt >= h + 1) begin
      w.value = filtered(h, hist_cnt >= 2 * h + 1, win, h);
      w.final_res = 1'b0;
      avg_q.insert(avg_q.size(), w);
      n = 1;
      m = h;
    end else begin
      m = hist_cnt;
    end
    // end of stream flushes the remaining edge outputs
    if (lst) begin
      while (m > 0) begin
        m--;
        w.value = filtered(m, 1'b0, win, h);
        w.final_res = 1'b0;
        avg_q.insert(avg_q.size(), w);
        n++;
      end
      if (n > 0) avg_q[avg_q.size()-1].final_res = 1'b1;
      hist_cnt = 0;
    end
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // register write, called and returning at a falling edge
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_WINDOW_SIZE) win_reg = data;
    else if (addr == REG_PASS_MODE) hp_mode = data[0];
    @(negedge clk);
  endtask

  // stop sending and wait until every owed word is back and the core is idle
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (avg_q.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // send one sample word, called and returning at a falling edge
  task automatic send_sample(logic [IN_W-1:0] smp, logic lst);
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    in_tlast <= lst;
    do @(posedge clk); while (!in_tready);
    predict_sample(smp[SAMPLE_BITS-1:0], lst);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [IN_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return IN_W'(16'sh7fff);
      1: return IN_W'(16'sh8000);
      2: return IN_W'($signed($urandom_range(0, 4)) - 2);
      default: return IN_W'($urandom);
    endcase
  endfunction

  // result side back-pressure
  initial begin
    forever begin
      @(negedge clk);
      if (out_stalls_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // compare each delivered word with the oldest prediction
  always @(posedge clk) begin : check_results
    avg_word_t        want;
    logic [OUT_W-1:0] want_data;
    if (rst_n && out_tvalid && out_tready) begin
      if (avg_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word, value %0d tlast %0b",
                                $signed(out_tdata[SAMPLE_BITS:0]), out_tlast));
      end else begin
        want = avg_q.pop_front();
        want_data = '0;
        want_data[SAMPLE_BITS:0] = want.value;
        if (out_tdata !== want_data || out_tlast !== want.final_res)
          note_mismatch($sformatf("expected value %0d tlast %0b, got %0d (tdata %h) tlast %0b",
                                  $signed(want.value), want.final_res,
                                  $signed(out_tdata[SAMPLE_BITS:0]), out_tdata, out_tlast));
      end
    end
  end

  // reset values: window 3, low-pass, extreme samples
  task automatic check_reset_defaults();
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hffff, 1'b0);
    send_sample(16'h0001, 1'b1);
  endtask

  // streams ending before any centered output, all words are edge flushes
  task automatic check_short_streams();
    wait_quiet();
    write_reg(REG_WINDOW_SIZE, 5'd7);
    write_reg(REG_PASS_MODE, 5'd1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h1234, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'hedcb, 1'b1);
  endtask

  // even window passes the sample, zero window behaves as even
  task automatic check_even_and_zero_windows();
    wait_quiet();
    write_reg(REG_WINDOW_SIZE, 5'd4);
    send_sample(16'h0100, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'hfff0, 1'b0);
    send_sample(16'h0003, 1'b1);
    wait_quiet();
    write_reg(REG_WINDOW_SIZE, 5'd0);
    write_reg(REG_PASS_MODE, 5'd0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'haaaa, 1'b0);
    send_sample(16'h8001, 1'b1);
  endtask

  // window shrinks in the middle of a stream
  task automatic check_window_change_midstream();
    wait_quiet();
    write_reg(REG_WINDOW_SIZE, 5'd5);
    send_sample(16'h0007, 1'b0);
    send_sample(16'hfff9, 1'b0);
    send_sample(16'h0064, 1'b0);
    send_sample(16'h8000, 1'b0);
    wait_quiet();
    write_reg(REG_WINDOW_SIZE, 5'd3);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h0011, 1'b0);
    send_sample(16'hff00, 1'b1);
  endtask

  // random settings, each followed by a few random streams
  task automatic check_random_streams();
    int phase;
    int win;
    int len;
    bit pass;
    phase = 0;
    while (items_sent < ITEMS_TARGET) begin
      case (phase)
        0: begin win = MAX_WIN; pass = 1'b0; end
        1: begin win = MAX_WIN; pass = 1'b1; end
        2: begin win = 1;       pass = 1'b0; end
        3: begin win = 0;       pass = 1'b1; end
        default: begin
          win = $urandom_range(0, MAX_WIN);
          pass = $urandom_range(0, 1);
        end
      endcase
      wait_quiet();
      write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(win));
      write_reg(REG_PASS_MODE, CFG_DATA_W'(pass));
      repeat ($urandom_range(1, 3)) begin
        if (items_sent < ITEMS_TARGET) begin
          len = $urandom_range(1, 2 * win + 8);
          if (len > ITEMS_TARGET - items_sent) len = ITEMS_TARGET - items_sent;
          for (int i = 0; i < len; i++) begin
            // final stretch runs at full rate on both sides
            if (items_sent >= ITEMS_TARGET - 50) begin
              in_gaps_on = 1'b0;
              out_stalls_on = 1'b0;
            end
            send_sample(rand_sample(), i == len - 1);
          end
        end
      end
      phase++;
    end
  endtask

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_reset_defaults();
    check_short_streams();
    check_even_and_zero_windows();
    check_window_change_midstream();
    check_random_streams();
    in_tvalid <= 1'b0;
    while (avg_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatches == 0 && avg_q.size() == 0) begin
      $display("** centered_moving_average_filter_core: PASSED **");
    end else begin
      $display("** centered_moving_average_filter_core: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("** centered_moving_average_filter_core: FAILED **");
    $finish;
  end

endmodule
